// File: hw/rtl/ldt_pkg.sv
package ldt_pkg;

   localparam int COORD_W = 16;
   localparam int SIZE_W  = 15;
   localparam int WORK_W  = 18;   // holds x + w and any difference of those
   localparam int CNT_W   = 7;
   localparam int PRES_W  = 32;
   localparam int PIX_W   = 48;
   localparam int PROD_W  = 2 * SIZE_W;
   localparam int FUNC_W  = 3;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INVALIDATE     = 3'd0,
      FUNC_INVALIDATE_ALL = 3'd1,
      FUNC_ADD            = 3'd2,
      FUNC_REMOVE         = 3'd3,
      FUNC_MOVE           = 3'd4,
      FUNC_SET_VISIBLE    = 3'd5,
      FUNC_PRESENT        = 3'd6,
      FUNC_QUERY          = 3'd7
   } func_type;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      alu_op_type        op;
      logic [WORK_W-1:0] a;
      logic [WORK_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [WORK_W-1:0] res;
      logic              neg;
   } alu_rsp_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [SIZE_W-1:0]  w;
      logic [SIZE_W-1:0]  h;
   } geom_type;

   function automatic logic [WORK_W-1:0] ext_coord(input logic [COORD_W-1:0] v);
      return {{(WORK_W-COORD_W){v[COORD_W-1]}}, v};
   endfunction

   function automatic logic [WORK_W-1:0] ext_size(input logic [SIZE_W-1:0] v);
      return {{(WORK_W-SIZE_W){1'b0}}, v};
   endfunction

endpackage

// File: hw/rtl/ldt_ram.sv
module ldt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                        wdata,
   output logic [WIDTH-1:0]                        rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hw/rtl/ldt_alu.sv
module ldt_alu
   import ldt_pkg::*;
(
   input  alu_req_type req,
   output alu_rsp_type rsp
);

   // single adder; subtract by inverting b and carrying in
   logic              sub;
   logic [WORK_W-1:0] b_eff;
   logic [WORK_W-1:0] sum;

   always_comb begin
      sub     = (req.op == ALU_SUB);
      b_eff   = sub ? ~req.b : req.b;
      sum     = req.a + b_eff + {{(WORK_W-1){1'b0}}, sub};
      rsp.res = sum;
      rsp.neg = sum[WORK_W-1];
   end

endmodule

// File: hw/rtl/layer_damage_tracker_core.sv
// Layer damage tracker: one command per transfer, one result per command.
// Query, invalidate all and a disabled tracker go straight to the result strobe; add scans
// for the lowest free slot, one slot per cycle; invalidate, present, remove, set visible and
// move step on the shared 18-bit add/compare unit, one step a cycle.
// Next command is taken in the strobe cycle; the receiver cannot stall the strobe.
// Synchronous active-high reset empties the layer table, damage and counters.
module layer_damage_tracker_core
   import ldt_pkg::*;
#(
   parameter int LAYER_SLOTS = 16
) (
   input  logic                      clock,
   input  logic                      reset,

   // command channel
   input  logic                      start,
   output logic                      busy,
   input  logic [FUNC_W-1:0]         req_func,
   input  logic signed [COORD_W-1:0] req_rect_x,
   input  logic signed [COORD_W-1:0] req_rect_y,
   input  logic [SIZE_W-1:0]         req_rect_width,
   input  logic [SIZE_W-1:0]         req_rect_height,
   input  logic [5:0]                req_layer_index,
   input  logic                      req_make_visible,

   // result channel
   output logic                      rsp_valid,
   output logic [CNT_W-1:0]          rsp_layer_slot,
   output logic signed [COORD_W-1:0] rsp_region_x,
   output logic signed [COORD_W-1:0] rsp_region_y,
   output logic [SIZE_W-1:0]         rsp_region_width,
   output logic [SIZE_W-1:0]         rsp_region_height,
   output logic                      rsp_region_presented,
   output logic                      rsp_layer_visible,
   output logic [CNT_W-1:0]          rsp_layer_count,
   output logic [PRES_W-1:0]         rsp_present_count,
   output logic [PIX_W-1:0]          rsp_pixels_presented,

   // register port
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [3:0]                paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);

   localparam int IDX_W = (LAYER_SLOTS > 1) ? $clog2(LAYER_SLOTS) : 1;
   localparam logic [CNT_W-1:0] SLOT_LIMIT = CNT_W'(LAYER_SLOTS);
   localparam logic [IDX_W-1:0] LAST_SLOT  = IDX_W'(LAYER_SLOTS - 1);

   typedef enum logic [1:0] {
      CSR_SCREEN_WIDTH,
      CSR_SCREEN_HEIGHT,
      CSR_ENABLED,
      CSR_SUSPENDED
   } csr_idx_type;

   // Sequencer steps. ST_R..ST_EB clip a rectangle against the screen and test it
   // for empty; ST_UL..ST_UB merge it with the held damage; ST_W/ST_H form the size.
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_FETCH,
      ST_R,
      ST_B,
      ST_CR,
      ST_CB,
      ST_ER,
      ST_EB,
      ST_UL,
      ST_UT,
      ST_DR,
      ST_UR,
      ST_DB,
      ST_UB,
      ST_W,
      ST_H,
      ST_MUL,
      ST_ACC,
      ST_RESP
   } state_type;

   // ---------------------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------------------
   logic [SIZE_W-1:0] screen_w_ff;
   logic [SIZE_W-1:0] screen_h_ff;
   logic              enabled_ff;
   logic              suspended_ff;
   logic              csr_write;
   csr_idx_type       csr_idx;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;
   assign csr_idx   = csr_idx_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_w_ff  <= SIZE_W'(1024);
         screen_h_ff  <= SIZE_W'(768);
         enabled_ff   <= 1'b1;
         suspended_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_idx)
            CSR_SCREEN_WIDTH:  screen_w_ff  <= pwdata[SIZE_W-1:0];
            CSR_SCREEN_HEIGHT: screen_h_ff  <= pwdata[SIZE_W-1:0];
            CSR_ENABLED:       enabled_ff   <= pwdata[0];
            CSR_SUSPENDED:     suspended_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_SCREEN_WIDTH:  prdata = {{(32-SIZE_W){1'b0}}, screen_w_ff};
         CSR_SCREEN_HEIGHT: prdata = {{(32-SIZE_W){1'b0}}, screen_h_ff};
         CSR_ENABLED:       prdata = {31'b0, enabled_ff};
         CSR_SUSPENDED:     prdata = {31'b0, suspended_ff};
         default:           prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------------------
   // Sequencer registers
   // ---------------------------------------------------------------------------------
   state_type          state_ff, state_in;

   // latched command
   func_type           func_ff, func_in;
   logic [COORD_W-1:0] rx_ff, rx_in;
   logic [COORD_W-1:0] ry_ff, ry_in;
   logic [SIZE_W-1:0]  rw_ff, rw_in;
   logic [SIZE_W-1:0]  rh_ff, rh_in;
   logic [5:0]         idx_ff, idx_in;
   logic               want_ff, want_in;

   // working set of the rectangle unit
   geom_type           src_ff, src_in;
   logic [WORK_W-1:0]  wl_ff, wl_in;
   logic [WORK_W-1:0]  wt_ff, wt_in;
   logic [WORK_W-1:0]  wr_ff, wr_in;
   logic [WORK_W-1:0]  wb_ff, wb_in;
   logic [WORK_W-1:0]  tmp_ff, tmp_in;
   logic               empty_ff, empty_in;
   logic               second_ff, second_in;       // move: new bounds still to damage
   logic               present_mode_ff, present_mode_in;
   logic [IDX_W-1:0]   scan_ff, scan_in;

   // block state
   logic [COORD_W-1:0]     dmg_x_ff, dmg_x_in;
   logic [COORD_W-1:0]     dmg_y_ff, dmg_y_in;
   logic [SIZE_W-1:0]      dmg_w_ff, dmg_w_in;
   logic [SIZE_W-1:0]      dmg_h_ff, dmg_h_in;
   logic [LAYER_SLOTS-1:0] occ_ff, occ_in;
   logic [LAYER_SLOTS-1:0] vis_ff, vis_in;
   logic [CNT_W-1:0]       used_ff, used_in;
   logic [PRES_W-1:0]      presents_ff, presents_in;
   logic [PIX_W-1:0]       pixels_ff, pixels_in;

   // presented region
   logic [COORD_W-1:0] out_x_ff, out_x_in;
   logic [COORD_W-1:0] out_y_ff, out_y_in;
   logic [SIZE_W-1:0]  out_w_ff, out_w_in;
   logic [SIZE_W-1:0]  out_h_ff, out_h_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [CNT_W-1:0]   slot_out_ff, slot_out_in;
   logic               presented_ff, presented_in;

   // result registers
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [COORD_W-1:0] rsp_x_ff, rsp_x_in;
   logic [COORD_W-1:0] rsp_y_ff, rsp_y_in;
   logic [SIZE_W-1:0]  rsp_w_ff, rsp_w_in;
   logic [SIZE_W-1:0]  rsp_h_ff, rsp_h_in;
   logic               rsp_presented_ff, rsp_presented_in;
   logic               rsp_visible_ff, rsp_visible_in;

   // shared unit and slot table
   alu_req_type        alu_req;
   alu_rsp_type        alu_rsp;
   logic               ram_we;
   logic [IDX_W-1:0]   ram_addr;
   geom_type           ram_wdata;
   geom_type           ram_rdata;

   logic [IDX_W-1:0]   slot_sel;
   logic               idx_in_range;
   logic               slot_valid;

   ldt_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   // geometry of each slot; only read for occupied slots, so never cleared
   ldt_ram #(
      .WIDTH ($bits(geom_type)),
      .DEPTH (LAYER_SLOTS)
   ) u_slot_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign slot_sel     = idx_ff[IDX_W-1:0];
   assign idx_in_range = ({1'b0, idx_ff} < SLOT_LIMIT);
   assign slot_valid   = idx_in_range && occ_ff[slot_sel];

   always_comb begin
      state_in         = state_ff;
      func_in          = func_ff;
      rx_in            = rx_ff;
      ry_in            = ry_ff;
      rw_in            = rw_ff;
      rh_in            = rh_ff;
      idx_in           = idx_ff;
      want_in          = want_ff;
      src_in           = src_ff;
      wl_in            = wl_ff;
      wt_in            = wt_ff;
      wr_in            = wr_ff;
      wb_in            = wb_ff;
      tmp_in           = tmp_ff;
      empty_in         = empty_ff;
      second_in        = second_ff;
      present_mode_in  = present_mode_ff;
      scan_in          = scan_ff;
      dmg_x_in         = dmg_x_ff;
      dmg_y_in         = dmg_y_ff;
      dmg_w_in         = dmg_w_ff;
      dmg_h_in         = dmg_h_ff;
      occ_in           = occ_ff;
      vis_in           = vis_ff;
      used_in          = used_ff;
      presents_in      = presents_ff;
      pixels_in        = pixels_ff;
      out_x_in         = out_x_ff;
      out_y_in         = out_y_ff;
      out_w_in         = out_w_ff;
      out_h_in         = out_h_ff;
      prod_in          = prod_ff;
      slot_out_in      = slot_out_ff;
      presented_in     = presented_ff;
      rsp_valid_in     = 1'b0;
      rsp_slot_in      = rsp_slot_ff;
      rsp_x_in         = rsp_x_ff;
      rsp_y_in         = rsp_y_ff;
      rsp_w_in         = rsp_w_ff;
      rsp_h_in         = rsp_h_ff;
      rsp_presented_in = rsp_presented_ff;
      rsp_visible_in   = rsp_visible_ff;

      alu_req.op = ALU_ADD;
      alu_req.a  = '0;
      alu_req.b  = '0;
      ram_we     = 1'b0;
      ram_addr   = slot_sel;        // prefetches the addressed slot during decode
      ram_wdata  = ram_rdata;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               func_in  = func_type'(req_func);
               rx_in    = req_rect_x;
               ry_in    = req_rect_y;
               rw_in    = req_rect_width;
               rh_in    = req_rect_height;
               idx_in   = req_layer_index;
               want_in  = req_make_visible;
               state_in = ST_DECODE;
            end
         end

         ST_DECODE: begin
            slot_out_in     = (func_ff == FUNC_ADD) ? SLOT_LIMIT : '0;
            presented_in    = 1'b0;
            second_in       = 1'b0;
            present_mode_in = 1'b0;
            state_in        = ST_RESP;
            if (enabled_ff) begin
               case (func_ff)
                  FUNC_INVALIDATE: begin
                     src_in.x = rx_ff;
                     src_in.y = ry_ff;
                     src_in.w = rw_ff;
                     src_in.h = rh_ff;
                     state_in = ST_R;
                  end
                  FUNC_INVALIDATE_ALL: begin
                     dmg_x_in = '0;
                     dmg_y_in = '0;
                     dmg_w_in = screen_w_ff;
                     dmg_h_in = screen_h_ff;
                  end
                  FUNC_ADD: begin
                     scan_in  = '0;
                     state_in = ST_SCAN;
                  end
                  FUNC_REMOVE: begin
                     // table bits go now; the geometry stays readable for the damage pass
                     if (slot_valid) begin
                        occ_in[slot_sel] = 1'b0;
                        vis_in[slot_sel] = 1'b0;
                        used_in          = used_ff - 1'b1;
                        if (vis_ff[slot_sel]) begin
                           state_in = ST_FETCH;
                        end
                     end
                  end
                  FUNC_MOVE: begin
                     if (slot_valid) begin
                        state_in = ST_FETCH;
                     end
                  end
                  FUNC_SET_VISIBLE: begin
                     if (slot_valid && (vis_ff[slot_sel] != want_ff)) begin
                        vis_in[slot_sel] = want_ff;
                        state_in         = ST_FETCH;
                     end
                  end
                  FUNC_PRESENT: begin
                     if (!suspended_ff) begin
                        if ((dmg_w_ff == '0) || (dmg_h_ff == '0)) begin
                           dmg_w_in = '0;
                           dmg_h_in = '0;
                        end else begin
                           src_in.x        = dmg_x_ff;
                           src_in.y        = dmg_y_ff;
                           src_in.w        = dmg_w_ff;
                           src_in.h        = dmg_h_ff;
                           present_mode_in = 1'b1;
                           state_in        = ST_R;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end

         // lowest free slot, one per cycle
         ST_SCAN: begin
            ram_addr = scan_ff;
            if (!occ_ff[scan_ff]) begin
               ram_we          = 1'b1;
               ram_wdata.x     = rx_ff;
               ram_wdata.y     = ry_ff;
               ram_wdata.w     = rw_ff;
               ram_wdata.h     = rh_ff;
               occ_in[scan_ff] = 1'b1;
               vis_in[scan_ff] = 1'b0;
               used_in         = used_ff + 1'b1;
               slot_out_in     = CNT_W'(scan_ff);
               state_in        = ST_RESP;
            end else if (scan_ff == LAST_SLOT) begin
               state_in = ST_RESP;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end

         // slot geometry is on ram_rdata here
         ST_FETCH: begin
            case (func_ff)
               FUNC_MOVE: begin
                  if ((ram_rdata.x == rx_ff) && (ram_rdata.y == ry_ff)) begin
                     state_in = ST_RESP;
                  end else begin
                     ram_we      = 1'b1;
                     ram_wdata.x = rx_ff;
                     ram_wdata.y = ry_ff;
                     src_in      = ram_rdata;
                     if (vis_ff[slot_sel]) begin
                        second_in = 1'b1;
                        state_in  = ST_R;
                     end else begin
                        state_in = ST_RESP;
                     end
                  end
               end
               default: begin
                  src_in   = ram_rdata;
                  state_in = ST_R;
               end
            endcase
         end

         ST_R: begin
            alu_req.a = ext_coord(src_ff.x);
            alu_req.b = ext_size(src_ff.w);
            wr_in     = alu_rsp.res;
            wl_in     = src_ff.x[COORD_W-1] ? '0 : ext_coord(src_ff.x);
            wt_in     = src_ff.y[COORD_W-1] ? '0 : ext_coord(src_ff.y);
            state_in  = ST_B;
         end

         ST_B: begin
            alu_req.a = ext_coord(src_ff.y);
            alu_req.b = ext_size(src_ff.h);
            wb_in     = alu_rsp.res;
            state_in  = ST_CR;
         end

         // right edge past the screen: clip
         ST_CR: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = ext_size(screen_w_ff);
            alu_req.b  = wr_ff;
            if (alu_rsp.neg) begin
               wr_in = ext_size(screen_w_ff);
            end
            state_in = ST_CB;
         end

         ST_CB: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = ext_size(screen_h_ff);
            alu_req.b  = wb_ff;
            if (alu_rsp.neg) begin
               wb_in = ext_size(screen_h_ff);
            end
            state_in = ST_ER;
         end

         // empty when right <= left
         ST_ER: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = wl_ff;
            alu_req.b  = wr_ff;
            empty_in   = !alu_rsp.neg;
            state_in   = ST_EB;
         end

         ST_EB: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = wt_ff;
            alu_req.b  = wb_ff;
            if (empty_ff || !alu_rsp.neg) begin
               if (present_mode_ff) begin
                  dmg_w_in = '0;
                  dmg_h_in = '0;
                  state_in = ST_RESP;
               end else if (second_ff) begin
                  second_in = 1'b0;
                  src_in.x  = rx_ff;
                  src_in.y  = ry_ff;
                  state_in  = ST_R;
               end else begin
                  state_in = ST_RESP;
               end
            end else if (!present_mode_ff && (dmg_w_ff != '0) && (dmg_h_ff != '0)) begin
               state_in = ST_UL;
            end else begin
               state_in = ST_W;
            end
         end

         // bounding union with held damage
         ST_UL: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = ext_coord(dmg_x_ff);
            alu_req.b  = wl_ff;
            if (alu_rsp.neg) begin
               wl_in = ext_coord(dmg_x_ff);
            end
            state_in = ST_UT;
         end

         ST_UT: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = ext_coord(dmg_y_ff);
            alu_req.b  = wt_ff;
            if (alu_rsp.neg) begin
               wt_in = ext_coord(dmg_y_ff);
            end
            state_in = ST_DR;
         end

         ST_DR: begin
            alu_req.a = ext_coord(dmg_x_ff);
            alu_req.b = ext_size(dmg_w_ff);
            tmp_in    = alu_rsp.res;
            state_in  = ST_UR;
         end

         ST_UR: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = wr_ff;
            alu_req.b  = tmp_ff;
            if (alu_rsp.neg) begin
               wr_in = tmp_ff;
            end
            state_in = ST_DB;
         end

         ST_DB: begin
            alu_req.a = ext_coord(dmg_y_ff);
            alu_req.b = ext_size(dmg_h_ff);
            tmp_in    = alu_rsp.res;
            state_in  = ST_UB;
         end

         ST_UB: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = wb_ff;
            alu_req.b  = tmp_ff;
            if (alu_rsp.neg) begin
               wb_in = tmp_ff;
            end
            state_in = ST_W;
         end

         // sizes are kept to 15 bits
         ST_W: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = wr_ff;
            alu_req.b  = wl_ff;
            if (present_mode_ff) begin
               out_w_in = alu_rsp.res[SIZE_W-1:0];
            end else begin
               dmg_w_in = alu_rsp.res[SIZE_W-1:0];
            end
            state_in = ST_H;
         end

         ST_H: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = wb_ff;
            alu_req.b  = wt_ff;
            if (present_mode_ff) begin
               out_h_in = alu_rsp.res[SIZE_W-1:0];
               out_x_in = wl_ff[COORD_W-1:0];
               out_y_in = wt_ff[COORD_W-1:0];
               state_in = ST_MUL;
            end else begin
               dmg_h_in = alu_rsp.res[SIZE_W-1:0];
               dmg_x_in = wl_ff[COORD_W-1:0];
               dmg_y_in = wt_ff[COORD_W-1:0];
               if (second_ff) begin
                  second_in = 1'b0;
                  src_in.x  = rx_ff;
                  src_in.y  = ry_ff;
                  state_in  = ST_R;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end

         ST_MUL: begin
            prod_in  = PROD_W'(out_w_ff) * PROD_W'(out_h_ff);
            state_in = ST_ACC;
         end

         ST_ACC: begin
            pixels_in    = pixels_ff + PIX_W'(prod_ff);
            presents_in  = presents_ff + 1'b1;
            presented_in = 1'b1;
            dmg_x_in     = '0;
            dmg_y_in     = '0;
            dmg_w_in     = '0;
            dmg_h_in     = '0;
            state_in     = ST_RESP;
         end

         ST_RESP: begin
            rsp_valid_in     = 1'b1;
            rsp_slot_in      = slot_out_ff;
            rsp_presented_in = presented_ff;
            rsp_visible_in   = slot_valid && vis_ff[slot_sel];
            if (presented_ff) begin
               rsp_x_in = out_x_ff;
               rsp_y_in = out_y_ff;
               rsp_w_in = out_w_ff;
               rsp_h_in = out_h_ff;
            end else begin
               rsp_x_in = dmg_x_ff;
               rsp_y_in = dmg_y_ff;
               rsp_w_in = dmg_w_ff;
               rsp_h_in = dmg_h_ff;
            end
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      func_in_latch: begin
         func_ff          <= func_in;
         rx_ff            <= rx_in;
         ry_ff            <= ry_in;
         rw_ff            <= rw_in;
         rh_ff            <= rh_in;
         idx_ff           <= idx_in;
         want_ff          <= want_in;
         src_ff           <= src_in;
         wl_ff            <= wl_in;
         wt_ff            <= wt_in;
         wr_ff            <= wr_in;
         wb_ff            <= wb_in;
         tmp_ff           <= tmp_in;
         empty_ff         <= empty_in;
         present_mode_ff  <= present_mode_in;
         scan_ff          <= scan_in;
         out_x_ff         <= out_x_in;
         out_y_ff         <= out_y_in;
         out_w_ff         <= out_w_in;
         out_h_ff         <= out_h_in;
         prod_ff          <= prod_in;
         slot_out_ff      <= slot_out_in;
         presented_ff     <= presented_in;
         rsp_slot_ff      <= rsp_slot_in;
         rsp_x_ff         <= rsp_x_in;
         rsp_y_ff         <= rsp_y_in;
         rsp_w_ff         <= rsp_w_in;
         rsp_h_ff         <= rsp_h_in;
         rsp_presented_ff <= rsp_presented_in;
         rsp_visible_ff   <= rsp_visible_in;
      end
      if (reset) begin
         state_ff     <= ST_IDLE;
         second_ff    <= 1'b0;
         dmg_x_ff     <= '0;
         dmg_y_ff     <= '0;
         dmg_w_ff     <= '0;
         dmg_h_ff     <= '0;
         occ_ff       <= '0;
         vis_ff       <= '0;
         used_ff      <= '0;
         presents_ff  <= '0;
         pixels_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         second_ff    <= second_in;
         dmg_x_ff     <= dmg_x_in;
         dmg_y_ff     <= dmg_y_in;
         dmg_w_ff     <= dmg_w_in;
         dmg_h_ff     <= dmg_h_in;
         occ_ff       <= occ_in;
         vis_ff       <= vis_in;
         used_ff      <= used_in;
         presents_ff  <= presents_in;
         pixels_ff    <= pixels_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy                 = (state_ff != ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_layer_slot       = rsp_slot_ff;
   assign rsp_region_x         = rsp_x_ff;
   assign rsp_region_y         = rsp_y_ff;
   assign rsp_region_width     = rsp_w_ff;
   assign rsp_region_height    = rsp_h_ff;
   assign rsp_region_presented = rsp_presented_ff;
   assign rsp_layer_visible    = rsp_visible_ff;
   // counters only move while busy, so they hold through the strobe cycle
   assign rsp_layer_count      = used_ff;
   assign rsp_present_count    = presents_ff;
   assign rsp_pixels_presented = pixels_ff;

endmodule
